// ===== hw/rtl/dtds_pkg.sv =====
// Package for datetime_difference_seconds: beat types, calendar constants
// and the per-stamp day-count functions.
// Depends on nothing.
package dtds_pkg;

    localparam int unsigned DAYS_W  = 23;
    localparam int unsigned TOTAL_W = 39;

    localparam logic [39:0] SECONDS_PER_DAY  = 40'd86400;
    localparam logic [16:0] SECONDS_PER_HOUR = 17'd3600;
    localparam logic [16:0] SECONDS_PER_MIN  = 17'd60;
    localparam logic [22:0] DAYS_PER_YEAR    = 23'd365;

    // floor(x / 100) = (x * RECIP_MUL) >> 22 and floor(x / 400) = (x * RECIP_MUL) >> 24,
    // exact for any 15-bit x
    localparam logic [30:0] RECIP_MUL = 31'd41944;
    // multiplicative inverse of 25 modulo 2^14; y is a multiple of 25 when
    // y * INV25 (mod 2^14) is at most floor((2^14 - 1) / 25)
    localparam logic [13:0] INV25     = 14'd7209;
    localparam logic [13:0] DIV25_MAX = 14'd655;

    typedef struct packed {
        logic [13:0] first_year;
        logic [3:0]  first_month;
        logic [4:0]  first_day;
        logic [4:0]  first_hour;
        logic [5:0]  first_minute;
        logic [5:0]  first_second;
        logic [13:0] second_year;
        logic [3:0]  second_month;
        logic [4:0]  second_day;
        logic [4:0]  second_hour;
        logic [5:0]  second_minute;
        logic [5:0]  second_sec;
    } stamps_t;

    typedef struct packed {
        logic [21:0] span_days;
        logic [4:0]  span_hours;
        logic [5:0]  span_minutes;
        logic [5:0]  span_seconds;
        logic [38:0] total_seconds;
    } result_t;

    typedef struct packed {
        logic [22:0] y365;
        logic [12:0] t4;
        logic [8:0]  q100;
        logic [8:0]  q400;
        logic [8:0]  mon;
        logic        leap_add;
        logic [4:0]  day;
        logic        day_carry;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  sec;
    } terms_t;

    // days first so that packed comparison orders stamps in time
    typedef struct packed {
        logic [DAYS_W-1:0] days;
        logic [4:0]        hour;
        logic [5:0]        minute;
        logic [5:0]        sec;
    } stamp_t;

    function automatic logic [8:0] month_days(input logic [3:0] mo);
        logic [8:0] d;
        unique case (mo)
            4'd0, 4'd1: d = 9'd0;
            4'd2:       d = 9'd31;
            4'd3:       d = 9'd59;
            4'd4:       d = 9'd90;
            4'd5:       d = 9'd120;
            4'd6:       d = 9'd151;
            4'd7:       d = 9'd181;
            4'd8:       d = 9'd212;
            4'd9:       d = 9'd243;
            4'd10:      d = 9'd273;
            4'd11:      d = 9'd304;
            4'd12:      d = 9'd334;
            default:    d = 9'd365;
        endcase
        return d;
    endfunction

    function automatic terms_t split_stamp(
        input logic [13:0] y,
        input logic [3:0]  mo,
        input logic [4:0]  d,
        input logic [4:0]  h,
        input logic [5:0]  mi,
        input logic [5:0]  s
    );
        logic [14:0] y99;
        logic [14:0] y399;
        logic [30:0] p100;
        logic [30:0] p400;
        logic [13:0] r25;
        logic        is4;
        logic        is25;
        logic        leap;
        logic        c1;
        logic        c2;
        logic [6:0]  m_sum;
        logic [5:0]  h_sum;
        logic [6:0]  m_adj;
        logic [5:0]  h_adj;
        terms_t      t;
        y99   = 15'(y) + 15'd99;
        y399  = 15'(y) + 15'd399;
        p100  = 31'(y99) * RECIP_MUL;
        p400  = 31'(y399) * RECIP_MUL;
        r25   = y * INV25;
        is25  = (r25 <= DIV25_MAX);
        is4   = (y[1:0] == 2'd0);
        leap  = (is4 && !is25) || ((y[3:0] == 4'd0) && is25);

        c1     = (s >= 6'd60);
        t.sec  = c1 ? (s - 6'd60) : s;
        m_sum  = 7'(mi) + 7'(c1);
        c2     = (m_sum >= 7'd60);
        m_adj  = c2 ? (m_sum - 7'd60) : m_sum;
        h_sum  = 6'(h) + 6'(c2);
        t.day_carry = (h_sum >= 6'd24);
        h_adj  = t.day_carry ? (h_sum - 6'd24) : h_sum;

        t.minute   = m_adj[5:0];
        t.hour     = h_adj[4:0];
        t.y365     = 23'(y) * DAYS_PER_YEAR;
        t.t4       = 13'((15'(y) + 15'd3) >> 2);
        t.q100     = p100[30:22];
        t.q400     = 9'(p400[30:24]);
        t.mon      = month_days(mo);
        t.leap_add = leap && (mo >= 4'd3);
        t.day      = d;
        return t;
    endfunction

    function automatic stamp_t stamp_days(input terms_t t);
        stamp_t st;
        st.days = t.y365 + 23'(t.t4) - 23'(t.q100) + 23'(t.q400) + 23'(t.mon)
                + 23'(t.leap_add) + 23'(t.day) + 23'(t.day_carry);
        st.hour   = t.hour;
        st.minute = t.minute;
        st.sec    = t.sec;
        return st;
    endfunction

endpackage

// ===== hw/rtl/datetime_difference_seconds.sv =====
// Top level of datetime_difference_seconds: absolute interval between two
// Gregorian date-times as days/hours/minutes/seconds and total seconds.
// Depends on dtds_pkg.
//
//  channel  | handshake      | payload
//  ---------+----------------+-----------------------------
//  command  | start / busy   | stamps  (dtds_pkg::stamps_t)
//  result   | done           | result  (dtds_pkg::result_t)
//
// One beat is taken every cycle; busy is always low.
// Each result appears in order, after its command beat has passed the input
// register and the five-stage pipeline behind it (split, day count, subtract,
// scale by a day, final add). The receiver cannot stall; done and result
// last one cycle. Reset clears only the beat valid flags.
module datetime_difference_seconds (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  dtds_pkg::stamps_t stamps,
    output logic              done,
    output dtds_pkg::result_t result
);
    import dtds_pkg::*;

    logic [5:0]  valid_reg;
    logic [5:0]  valid_next;

    stamps_t     in_reg;
    terms_t      ta_reg;
    terms_t      tb_reg;
    stamp_t      sa_reg;
    stamp_t      sb_reg;
    stamp_t      diff_reg;
    stamp_t      span_reg;
    logic [39:0] prod_reg;
    logic [16:0] sod_reg;
    result_t     result_reg;

    terms_t      ta_next;
    terms_t      tb_next;
    stamp_t      big;
    stamp_t      small_st;
    stamp_t      diff_next;
    logic [6:0]  s_d;
    logic [6:0]  m_d;
    logic [5:0]  h_d;
    logic        b1;
    logic        b2;
    logic        b3;
    logic [39:0] prod_next;
    logic [16:0] sod_next;
    logic [39:0] total_sum;
    result_t     result_next;

    assign busy   = 1'b0;
    assign done   = valid_reg[5];
    assign result = result_reg;

    assign valid_next = {valid_reg[4:0], start};

    always_comb
    begin
        ta_next = split_stamp(in_reg.first_year, in_reg.first_month, in_reg.first_day,
                              in_reg.first_hour, in_reg.first_minute,
                              in_reg.first_second);
        tb_next = split_stamp(in_reg.second_year, in_reg.second_month,
                              in_reg.second_day, in_reg.second_hour,
                              in_reg.second_minute, in_reg.second_sec);
    end

    always_comb
    begin
        if (sa_reg >= sb_reg)
        begin
            big      = sa_reg;
            small_st = sb_reg;
        end
        else
        begin
            big      = sb_reg;
            small_st = sa_reg;
        end
        s_d = 7'(big.sec) - 7'(small_st.sec);
        b1  = s_d[6];
        diff_next.sec = b1 ? 6'(s_d + 7'd60) : s_d[5:0];
        m_d = 7'(big.minute) - 7'(small_st.minute) - 7'(b1);
        b2  = m_d[6];
        diff_next.minute = b2 ? 6'(m_d + 7'd60) : m_d[5:0];
        h_d = 6'(big.hour) - 6'(small_st.hour) - 6'(b2);
        b3  = h_d[5];
        diff_next.hour = b3 ? 5'(h_d + 6'd24) : h_d[4:0];
        diff_next.days = big.days - small_st.days - DAYS_W'(b3);
    end

    always_comb
    begin
        prod_next = 40'(diff_reg.days) * SECONDS_PER_DAY;
        sod_next  = 17'(diff_reg.hour) * SECONDS_PER_HOUR
                  + 17'(diff_reg.minute) * SECONDS_PER_MIN
                  + 17'(diff_reg.sec);
    end

    always_comb
    begin
        total_sum                 = prod_reg + 40'(sod_reg);
        result_next.span_days     = span_reg.days[21:0];
        result_next.span_hours    = span_reg.hour;
        result_next.span_minutes  = span_reg.minute;
        result_next.span_seconds  = span_reg.sec;
        result_next.total_seconds = total_sum[TOTAL_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload advances every cycle; valid_reg tags the live beats
    always_ff @(posedge clk)
    begin
        in_reg     <= stamps;
        ta_reg     <= ta_next;
        tb_reg     <= tb_next;
        sa_reg     <= stamp_days(ta_reg);
        sb_reg     <= stamp_days(tb_reg);
        diff_reg   <= diff_next;
        prod_reg   <= prod_next;
        sod_reg    <= sod_next;
        span_reg   <= diff_reg;
        result_reg <= result_next;
    end

endmodule

// ===== sim/datetime_difference_seconds_tb.sv =====
// Testbench for datetime_difference_seconds: random and directed stamp pairs on the
// start/busy command port, intervals checked against an in-bench calendar predictor.
// Depends on dtds_pkg and the datetime_difference_seconds RTL.
module datetime_difference_seconds_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dtds_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT   = 1000;
    localparam int unsigned TAIL_CYCLES      = 12;
    localparam int unsigned RANDOM_PER_PHASE = 530;
    localparam int unsigned REPORT_CAP       = 40;

    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  sec;
    } moment_t;

    class span_scoreboard;
        result_t     expected_spans[$];
        int unsigned noted   = 0;
        int unsigned checked = 0;
        int unsigned errors  = 0;
        int unsigned cum_days[16] = '{0, 0, 31, 59, 90, 120, 151, 181,
                                      212, 243, 273, 304, 334, 365, 365, 365};

        function bit is_leap(longint unsigned y);
            return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
        endfunction

        function longint unsigned seconds_from_year_zero(
            logic [13:0] y, logic [3:0] mo, logic [4:0] d,
            logic [4:0] h, logic [5:0] mi, logic [5:0] s);
            longint unsigned yy;
            longint unsigned days;
            yy   = y;
            days = 365 * yy + (yy + 3) / 4 - (yy + 99) / 100 + (yy + 399) / 400;
            days += cum_days[mo];
            if (mo >= 3 && is_leap(yy))
                days += 1;
            days += d;
            return days * 86400 + longint'(h) * 3600 + longint'(mi) * 60 + longint'(s);
        endfunction

        function void note_stamps(stamps_t s);
            longint unsigned a;
            longint unsigned b;
            longint unsigned diff;
            longint unsigned rem;
            result_t         r;
            a = seconds_from_year_zero(s.first_year, s.first_month, s.first_day,
                                       s.first_hour, s.first_minute, s.first_second);
            b = seconds_from_year_zero(s.second_year, s.second_month, s.second_day,
                                       s.second_hour, s.second_minute, s.second_sec);
            diff = (a >= b) ? (a - b) : (b - a);
            rem  = diff % 86400;
            r.span_days     = 22'(diff / 86400);
            r.span_hours    = 5'(rem / 3600);
            rem             = rem % 3600;
            r.span_minutes  = 6'(rem / 60);
            r.span_seconds  = 6'(rem % 60);
            r.total_seconds = 39'(diff);
            expected_spans.push_back(r);
            noted++;
        endfunction

        function void compare_field(string field, logic [63:0] want, logic [63:0] seen);
            if (want !== seen)
            begin
                errors++;
                if (errors <= REPORT_CAP)
                    $display("%0t: %s expected %0d actual %0d", $time, field, want, seen);
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (expected_spans.size() == 0)
            begin
                errors++;
                if (errors <= REPORT_CAP)
                    $display("%0t: unexpected result beat, expected none actual %h",
                             $time, got);
                return;
            end
            want = expected_spans.pop_front();
            checked++;
            compare_field("span_days", 64'(want.span_days), 64'(got.span_days));
            compare_field("span_hours", 64'(want.span_hours), 64'(got.span_hours));
            compare_field("span_minutes", 64'(want.span_minutes), 64'(got.span_minutes));
            compare_field("span_seconds", 64'(want.span_seconds), 64'(got.span_seconds));
            compare_field("total_seconds", 64'(want.total_seconds), 64'(got.total_seconds));
        endfunction
    endclass

    logic    clk = 1'b0;
    logic    rst_n;
    logic    start;
    logic    busy;
    stamps_t stamps;
    logic    done;
    result_t result;

    span_scoreboard board = new;
    int unsigned    idle_pct;
    int unsigned    sent;
    int unsigned    directed_count;
    int unsigned    quiet_cycles = 0;

    datetime_difference_seconds DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .stamps (stamps),
        .done   (done),
        .result (result)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
            board.note_stamps(stamps);
        if (rst_n && done)
            board.check_result(result);
        if ((rst_n && start && !busy) || (rst_n && done))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("datetime_difference_seconds regression: fail");
            $finish;
        end
    end

    function automatic moment_t mk(int unsigned y, int unsigned mo, int unsigned d,
                                   int unsigned h, int unsigned mi, int unsigned s);
        moment_t m;
        m.year   = 14'(y);
        m.month  = 4'(mo);
        m.day    = 5'(d);
        m.hour   = 5'(h);
        m.minute = 6'(mi);
        m.sec    = 6'(s);
        return m;
    endfunction

    function automatic stamps_t pair(moment_t a, moment_t b);
        return {a, b};
    endfunction

    function automatic moment_t random_moment(bit wild);
        if (wild)
            return mk($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        return mk($urandom_range(9999), $urandom_range(1, 12),
                  ($urandom_range(9) == 0) ? $urandom_range(29, 31) : $urandom_range(1, 28),
                  $urandom_range(23), $urandom_range(59), $urandom_range(59));
    endfunction

    function automatic stamps_t random_pair();
        int unsigned pick;
        int unsigned y;
        moment_t     a;
        moment_t     b;
        pick = $urandom_range(99);
        a    = random_moment(pick >= 85);
        if (pick < 40)
            b = random_moment(1'b0);
        else if (pick < 70)
        begin
            b = a;
            case ($urandom_range(4))
                0: b.sec    = 6'($urandom_range(59));
                1: b.minute = 6'($urandom_range(59));
                2: b.day    = 5'($urandom_range(1, 31));
                3: b.month  = 4'($urandom_range(1, 12));
                default: b.year = 14'(a.year + $urandom_range(3));
            endcase
        end
        else if (pick < 85)
        begin
            y = 100 * $urandom_range(99) + $urandom_range(4);
            a = mk(y, 2, $urandom_range(27, 29), $urandom_range(23),
                   $urandom_range(59), $urandom_range(59));
            b = mk(y + $urandom_range(1), 3, $urandom_range(1, 2), $urandom_range(23),
                   $urandom_range(59), $urandom_range(59));
        end
        else
            b = random_moment($urandom_range(1));
        return ($urandom_range(1) == 0) ? pair(a, b) : pair(b, a);
    endfunction

    task automatic send_pair(input stamps_t s);
        logic [127:0] noise;
        while ($urandom_range(99) < idle_pct)
        begin
            noise  = {$urandom, $urandom, $urandom, $urandom};
            start  <= 1'b0;
            stamps <= noise[$bits(stamps_t)-1:0];
            @(posedge clk);
        end
        start  <= 1'b1;
        stamps <= s;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sent++;
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (board.expected_spans.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        rst_n    = 1'b0;
        start    = 1'b0;
        stamps   = '0;
        idle_pct = 33;
        sent     = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_pair(pair(mk(0, 1, 1, 0, 0, 0), mk(0, 1, 1, 0, 0, 0)));
        send_pair(pair(mk(0, 1, 1, 0, 0, 0), mk(9999, 12, 31, 23, 59, 59)));
        send_pair(pair(mk(9999, 12, 31, 23, 59, 59), mk(0, 1, 1, 0, 0, 0)));
        send_pair(pair(mk(2000, 2, 29, 12, 0, 0), mk(2000, 3, 1, 12, 0, 0)));
        send_pair(pair(mk(1900, 2, 28, 0, 0, 0), mk(1900, 3, 1, 0, 0, 0)));
        send_pair(pair(mk(2023, 3, 1, 6, 30, 0), mk(2024, 3, 1, 6, 30, 0)));
        send_pair(pair(mk(2024, 0, 5, 0, 0, 0), mk(2024, 1, 5, 0, 0, 0)));
        send_pair(pair(mk(2023, 13, 1, 0, 0, 0), mk(2024, 1, 1, 0, 0, 0)));
        send_pair(pair(mk(2024, 14, 0, 0, 0, 0), mk(2024, 15, 31, 0, 0, 0)));
        send_pair(pair(mk(2021, 2, 0, 0, 0, 0), mk(2021, 2, 31, 0, 0, 0)));
        send_pair(pair(mk(2020, 6, 15, 31, 63, 63), mk(2020, 6, 15, 0, 0, 0)));
        send_pair(pair(mk(2020, 6, 15, 23, 59, 59), mk(2020, 6, 16, 0, 0, 0)));
        send_pair(pair(mk(16383, 15, 31, 31, 63, 63), mk(0, 0, 0, 0, 0, 0)));
        send_pair(pair(mk(16383, 7, 4, 5, 6, 7), mk(10000, 1, 1, 0, 0, 0)));
        send_pair(pair(mk(0, 2, 29, 0, 0, 0), mk(0, 3, 1, 0, 0, 0)));
        send_pair(pair(mk(400, 3, 1, 0, 0, 0), mk(399, 3, 1, 0, 0, 0)));
        send_pair(pair(mk(9999, 12, 31, 23, 59, 59), mk(9999, 12, 31, 23, 59, 58)));
        send_pair(pair(mk(14'h2AAA, 4'h5, 5'h0A, 5'h15, 6'h2A, 6'h15),
                       mk(14'h1555, 4'hA, 5'h15, 5'h0A, 6'h15, 6'h2A)));
        directed_count = sent;

        for (int phase = 0; phase < 3; phase++)
        begin
            idle_pct = (phase == 0) ? 33 : (phase == 1) ? 60 : 0;
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
                send_pair(random_pair());
            drain();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (board.expected_spans.size() != 0)
        begin
            $display("%0t: %0d results expected but never seen", $time,
                     board.expected_spans.size());
            board.errors += board.expected_spans.size();
        end

        $display("sent %0d stamp pairs (%0d directed) under 33%%, 60%% and no sender idling",
                 sent, directed_count);
        $display("compared %0d intervals field by field, %0d mismatches",
                 board.checked, board.errors);
        if (board.errors == 0)
            $display("datetime_difference_seconds regression: pass");
        else
            $display("datetime_difference_seconds regression: fail");
        $finish;
    end

endmodule
